### design/run_backref_byte_decoder_unit_macros.svh
// Assertion macros for the run/back-reference byte decoder.
`ifndef RUN_BACKREF_BYTE_DECODER_UNIT_MACROS_SVH
`define RUN_BACKREF_BYTE_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RBBD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("rbbd: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RBBD_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("rbbd: next-cycle check failed");

`endif

### design/rbbd_pkg.sv
// Types, codes and constants shared by the run/back-reference byte decoder.
`default_nettype none

package rbbd_pkg;

  localparam int DEF_HISTORY_DEPTH = 512;
  localparam int DEF_LENGTH_BITS   = 24;

  // Opcode ranges
  localparam logic [7:0] OP_ZERO_BASE = 8'd64;
  localparam logic [7:0] OP_RUN_BASE  = 8'd128;
  localparam logic [7:0] OP_BREF_BASE = 8'd192;
  localparam logic [7:0] OP_INVALID   = 8'd254;
  localparam logic [7:0] OP_END       = 8'd255;

  localparam logic [6:0] LIT_BIAS   = 7'd1;
  localparam logic [6:0] SHORT_BIAS = 7'd2;
  localparam logic [8:0] DIST_BIAS  = 9'd2;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_INPUT_LENGTH  = 1'b0;
  localparam cfg_idx_t CFG_OUTPUT_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    MODE_OPCODE   = 3'd0,
    MODE_LITERAL  = 3'd1,
    MODE_RUN_DATA = 3'd2,
    MODE_DISTANCE = 3'd3,
    MODE_DONE     = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_IN_OVERRUN  = 3'd1,
    STAT_OUT_OVERRUN = 3'd2,
    STAT_UNDERFLOW   = 3'd3,
    STAT_INVALID     = 3'd4,
    STAT_MISMATCH    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ENG_IDLE = 2'd0,
    ENG_GEN  = 2'd1,
    ENG_FIN  = 2'd2
  } eng_t;

  // Decision for one accepted byte
  typedef struct packed {
    mode_t      mode_nxt;
    logic [6:0] pend_nxt;
    logic [6:0] gen_len;
    logic       gen_copy;
    logic [7:0] gen_byte;
    logic [8:0] distance;
    logic       done;
    status_t    status;
  } dec_t;

endpackage

`default_nettype wire

### design/rbbd_if.sv
// Valid/ready channel interfaces for compressed input and decoded results.
`default_nettype none

interface rbbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface rbbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_a;
  logic [7:0] byte_b;
  logic [1:0] byte_count;
  logic       run_end;
  logic       done_res;
  logic [2:0] status;

  modport source (output valid, output byte_a, output byte_b, output byte_count,
                  output run_end, output done_res, output status, input ready);
  modport sink   (input valid, input byte_a, input byte_b, input byte_count,
                  input run_end, input done_res, input status, output ready);
endinterface

`default_nettype wire

### design/run_backref_byte_decoder_unit.sv
// Top level: byte-opcode run/back-reference decoder with a history ring memory.
// An input byte is taken in any cycle the engine is idle.
// A byte that yields decoded bytes holds the engine while they are generated, one history write
// each, and then while a pending done result goes out; decoded bytes are paired where possible.
// Output register decouples the result channel; stalls there pause generation and done results.
// Synchronous active-low reset clears counters, mode and lengths; history is not cleared.
`default_nettype none

`include "run_backref_byte_decoder_unit_macros.svh"

module run_backref_byte_decoder_unit
  import rbbd_pkg::*;
#(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int LENGTH_BITS   = DEF_LENGTH_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  rbbd_in_if.sink                in_s,
  rbbd_out_if.source             out_m,
  input  logic                   cfg_we,
  input  cfg_idx_t               cfg_index,
  input  logic [LENGTH_BITS-1:0] cfg_data
);

  localparam int            HW        = $clog2(HISTORY_DEPTH);
  localparam logic [HW-1:0] HIST_LAST = HW'(HISTORY_DEPTH - 1);
  localparam logic [HW:0]   HIST_SPAN = (HW+1)'(HISTORY_DEPTH);

  function automatic logic [HW-1:0] hist_inc(input logic [HW-1:0] ptr);
    hist_inc = (ptr == HIST_LAST) ? '0 : ptr + 1'b1;
  endfunction

  logic [LENGTH_BITS-1:0] in_len_r, out_len_r;
  logic [LENGTH_BITS-1:0] cons_r, cons_nxt;   // count of bytes taken, plus one
  logic [LENGTH_BITS-1:0] prod_r, prod_nxt, prod_dec;
  mode_t                  mode_r, mode_nxt;
  logic [6:0]             pend_r, pend_nxt;
  eng_t                   eng_r, eng_nxt;
  logic [6:0]             gen_rem_r, gen_rem_nxt;
  logic                   gen_copy_r, gen_copy_nxt;
  logic [7:0]             gen_byte_r, gen_byte_nxt;
  logic                   done_pend_r, done_pend_nxt;
  status_t                done_st_r, done_st_nxt;
  logic                   pair_has_r, pair_has_nxt;
  logic [7:0]             pair_a_r, pair_a_nxt;
  logic [HW-1:0]          hp_r, hp_nxt;
  logic [HW-1:0]          rd_ptr_r, rd_ptr_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_a_r, out_a_nxt;
  logic [7:0]             out_b_r, out_b_nxt;
  logic [1:0]             out_cnt_r, out_cnt_nxt;
  logic                   out_end_r, out_end_nxt;
  logic                   out_done_r, out_done_nxt;
  status_t                out_st_r, out_st_nxt;

  logic [7:0]             hist_mem [HISTORY_DEPTH];
  logic [7:0]             rdata_r;
  logic                   mem_we, mem_re;
  logic [HW-1:0]          mem_wa, mem_ra;
  logic [7:0]             mem_wd;

  dec_t                   dec;
  logic                   in_fire, take, out_free;
  logic [7:0]             cur_byte;
  logic                   last_byte, emit, adv;
  logic [HW:0]            ref_diff, ref_wrap;
  logic [HW-1:0]          ref_addr;

  rbbd_opdec #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_opdec (
    .mode_i     (mode_r),
    .pend_i     (pend_r),
    .byte_i     (in_s.in_byte),
    .cons_i     (cons_r),
    .prod_i     (prod_r),
    .in_len_i   (in_len_r),
    .out_len_i  (out_len_r),
    .dec_o      (dec),
    .prod_nxt_o (prod_dec)
  );

  assign in_s.ready = (eng_r == ENG_IDLE);
  assign in_fire    = in_s.valid && in_s.ready;
  assign take       = in_fire && (mode_r != MODE_DONE);
  assign out_free   = !out_valid_r || out_m.ready;

  assign cur_byte  = gen_copy_r ? rdata_r : gen_byte_r;
  assign last_byte = (gen_rem_r == 7'd1);
  assign emit      = pair_has_r || last_byte;
  assign adv       = (eng_r == ENG_GEN) && (!emit || out_free);

  // First copy source: write pointer minus distance, modulo ring depth
  assign ref_diff = {1'b0, hp_r} - (HW+1)'(dec.distance);
  assign ref_wrap = ref_diff + HIST_SPAN;
  assign ref_addr = ({1'b0, hp_r} >= (HW+1)'(dec.distance)) ? ref_diff[HW-1:0] :
                                                             ref_wrap[HW-1:0];

  always_comb begin
    eng_nxt = eng_r;
    case (eng_r)
      ENG_IDLE: begin
        if (take) begin
          if (dec.gen_len != 7'd0) eng_nxt = ENG_GEN;
          else if (dec.done)       eng_nxt = ENG_FIN;
        end
      end
      ENG_GEN: begin
        if (adv && last_byte) eng_nxt = done_pend_r ? ENG_FIN : ENG_IDLE;
      end
      ENG_FIN: begin
        if (out_free) eng_nxt = ENG_IDLE;
      end
      default: eng_nxt = ENG_IDLE;
    endcase
  end

  always_comb begin
    cons_nxt      = cons_r;
    prod_nxt      = prod_r;
    mode_nxt      = mode_r;
    pend_nxt      = pend_r;
    gen_rem_nxt   = gen_rem_r;
    gen_copy_nxt  = gen_copy_r;
    gen_byte_nxt  = gen_byte_r;
    done_pend_nxt = done_pend_r;
    done_st_nxt   = done_st_r;
    pair_has_nxt  = pair_has_r;
    pair_a_nxt    = pair_a_r;
    hp_nxt        = hp_r;
    rd_ptr_nxt    = rd_ptr_r;
    out_valid_nxt = out_valid_r && !out_m.ready;
    out_a_nxt     = out_a_r;
    out_b_nxt     = out_b_r;
    out_cnt_nxt   = out_cnt_r;
    out_end_nxt   = out_end_r;
    out_done_nxt  = out_done_r;
    out_st_nxt    = out_st_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_wa        = hp_r;
    mem_ra        = rd_ptr_r;
    mem_wd        = cur_byte;

    case (eng_r)
      ENG_IDLE: begin
        if (take) begin
          cons_nxt      = cons_r + LENGTH_BITS'(1);
          prod_nxt      = prod_dec;
          mode_nxt      = dec.mode_nxt;
          pend_nxt      = dec.pend_nxt;
          gen_rem_nxt   = dec.gen_len;
          gen_copy_nxt  = dec.gen_copy;
          gen_byte_nxt  = dec.gen_byte;
          done_pend_nxt = dec.done;
          done_st_nxt   = dec.status;
          if (dec.gen_copy) begin
            mem_re     = 1'b1;
            mem_ra     = ref_addr;
            rd_ptr_nxt = hist_inc(ref_addr);
          end
        end
      end
      ENG_GEN: begin
        if (adv) begin
          mem_we      = 1'b1;
          hp_nxt      = hist_inc(hp_r);
          gen_rem_nxt = gen_rem_r - 7'd1;
          // distance is at least two, so the next read never hits this write
          if (gen_copy_r && !last_byte) begin
            mem_re     = 1'b1;
            rd_ptr_nxt = hist_inc(rd_ptr_r);
          end
          if (pair_has_r) begin
            out_valid_nxt = 1'b1;
            out_a_nxt     = pair_a_r;
            out_b_nxt     = cur_byte;
            out_cnt_nxt   = 2'd2;
            out_end_nxt   = last_byte && !done_pend_r;
            out_done_nxt  = 1'b0;
            out_st_nxt    = STAT_OK;
            pair_has_nxt  = 1'b0;
          end else if (last_byte) begin
            out_valid_nxt = 1'b1;
            out_a_nxt     = cur_byte;
            out_b_nxt     = 8'd0;
            out_cnt_nxt   = 2'd1;
            out_end_nxt   = !done_pend_r;
            out_done_nxt  = 1'b0;
            out_st_nxt    = STAT_OK;
          end else begin
            pair_a_nxt   = cur_byte;
            pair_has_nxt = 1'b1;
          end
        end
      end
      ENG_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_a_nxt     = 8'd0;
          out_b_nxt     = 8'd0;
          out_cnt_nxt   = 2'd0;
          out_end_nxt   = 1'b1;
          out_done_nxt  = 1'b1;
          out_st_nxt    = done_st_r;
          done_pend_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_r <= hist_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_len_r  <= LENGTH_BITS'(1);
      out_len_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INPUT_LENGTH:  in_len_r  <= cfg_data;
        CFG_OUTPUT_LENGTH: out_len_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eng_r       <= ENG_IDLE;
      mode_r      <= MODE_OPCODE;
      pend_r      <= 7'd0;
      cons_r      <= LENGTH_BITS'(1);
      prod_r      <= '0;
      hp_r        <= '0;
      gen_rem_r   <= 7'd0;
      gen_copy_r  <= 1'b0;
      done_pend_r <= 1'b0;
      pair_has_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      eng_r       <= eng_nxt;
      mode_r      <= mode_nxt;
      pend_r      <= pend_nxt;
      cons_r      <= cons_nxt;
      prod_r      <= prod_nxt;
      hp_r        <= hp_nxt;
      gen_rem_r   <= gen_rem_nxt;
      gen_copy_r  <= gen_copy_nxt;
      done_pend_r <= done_pend_nxt;
      pair_has_r  <= pair_has_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gen_byte_r <= gen_byte_nxt;
    done_st_r  <= done_st_nxt;
    pair_a_r   <= pair_a_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    out_a_r    <= out_a_nxt;
    out_b_r    <= out_b_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_end_r  <= out_end_nxt;
    out_done_r <= out_done_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign out_m.valid      = out_valid_r;
  assign out_m.byte_a     = out_a_r;
  assign out_m.byte_b     = out_b_r;
  assign out_m.byte_count = out_cnt_r;
  assign out_m.run_end    = out_end_r;
  assign out_m.done_res   = out_done_r;
  assign out_m.status     = out_st_r;

  `RBBD_ASSERT_IMP(a_rw_apart, clk, rst_n, mem_we && mem_re, mem_wa != mem_ra)
  `RBBD_ASSERT_IMP(a_pair_empty_idle, clk, rst_n, eng_r == ENG_IDLE, !pair_has_r)
  `RBBD_ASSERT_IMP(a_gen_nonzero, clk, rst_n, eng_r == ENG_GEN, gen_rem_r != 7'd0)
  `RBBD_ASSERT_IMP(a_fin_pending, clk, rst_n, eng_r == ENG_FIN, done_pend_r)
  `RBBD_ASSERT_NXT(a_done_sticky, clk, rst_n, out_valid_r && out_m.ready && out_done_r,
                   mode_r == MODE_DONE)

endmodule

`default_nettype wire

### design/rbbd_opdec.sv
// Opcode decode and length checks for one compressed byte.
`default_nettype none

module rbbd_opdec
  import rbbd_pkg::*;
#(
  parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
  input  mode_t                  mode_i,
  input  logic [6:0]             pend_i,
  input  logic [7:0]             byte_i,
  input  logic [LENGTH_BITS-1:0] cons_i,     // consumed count including this byte
  input  logic [LENGTH_BITS-1:0] prod_i,
  input  logic [LENGTH_BITS-1:0] in_len_i,
  input  logic [LENGTH_BITS-1:0] out_len_i,
  output dec_t                   dec_o,
  output logic [LENGTH_BITS-1:0] prod_nxt_o
);

  logic [6:0]             lit_len;
  logic [6:0]             short_len;
  logic [6:0]             chk_len;
  logic [8:0]             distance;
  logic                   in_end;
  logic                   ovf_in;
  logic                   ovf_out;
  logic                   underflow;
  logic                   err;
  logic                   fin;
  logic [6:0]             lit_left;
  logic [LENGTH_BITS-1:0] prod_nxt;

  assign lit_len   = {1'b0, byte_i[5:0]} + LIT_BIAS;
  assign short_len = {1'b0, byte_i[5:0]} + SHORT_BIAS;
  assign distance  = {1'b0, byte_i} + DIST_BIAS;
  assign lit_left  = pend_i - 7'd1;
  assign chk_len   = (mode_i == MODE_DISTANCE) ? pend_i :
                     (byte_i < OP_ZERO_BASE)   ? lit_len : short_len;

  // len > remaining is the same as count + len > limit, since len is never zero
  assign in_end    = (cons_i >= in_len_i);
  assign ovf_in    = ({1'b0, cons_i} + (LENGTH_BITS+1)'(lit_len)) > {1'b0, in_len_i};
  assign ovf_out   = ({1'b0, prod_i} + (LENGTH_BITS+1)'(chk_len)) > {1'b0, out_len_i};
  assign underflow = {{LENGTH_BITS{1'b0}}, distance} > {9'd0, prod_i};

  always_comb begin
    dec_o          = '0;
    dec_o.mode_nxt = mode_i;
    dec_o.pend_nxt = pend_i;
    dec_o.gen_byte = byte_i;
    dec_o.distance = distance;
    dec_o.status   = STAT_OK;
    err            = 1'b0;
    fin            = 1'b0;

    case (mode_i)
      MODE_OPCODE: begin
        case (byte_i) inside
          [8'd0 : OP_ZERO_BASE - 8'd1]: begin
            if (ovf_in) begin
              err = 1'b1; dec_o.status = STAT_IN_OVERRUN;
            end else if (ovf_out) begin
              err = 1'b1; dec_o.status = STAT_OUT_OVERRUN;
            end else begin
              dec_o.mode_nxt = MODE_LITERAL;
              dec_o.pend_nxt = lit_len;
            end
          end
          [OP_ZERO_BASE : OP_RUN_BASE - 8'd1]: begin
            if (ovf_out) begin
              err = 1'b1; dec_o.status = STAT_OUT_OVERRUN;
            end else begin
              dec_o.gen_len  = short_len;
              dec_o.gen_byte = 8'd0;
            end
          end
          [OP_RUN_BASE : OP_BREF_BASE - 8'd1]: begin
            if (in_end) begin
              err = 1'b1; dec_o.status = STAT_IN_OVERRUN;
            end else if (ovf_out) begin
              err = 1'b1; dec_o.status = STAT_OUT_OVERRUN;
            end else begin
              dec_o.mode_nxt = MODE_RUN_DATA;
              dec_o.pend_nxt = short_len;
            end
          end
          [OP_BREF_BASE : OP_INVALID - 8'd1]: begin
            if (in_end) begin
              err = 1'b1; dec_o.status = STAT_IN_OVERRUN;
            end else begin
              dec_o.mode_nxt = MODE_DISTANCE;
              dec_o.pend_nxt = short_len;
            end
          end
          OP_INVALID: begin
            err = 1'b1; dec_o.status = STAT_INVALID;
          end
          default: fin = 1'b1;  // terminator
        endcase
      end
      MODE_LITERAL: begin
        dec_o.gen_len  = 7'd1;
        dec_o.pend_nxt = lit_left;
        if (lit_left == 7'd0) dec_o.mode_nxt = MODE_OPCODE;
      end
      MODE_RUN_DATA: begin
        dec_o.gen_len  = pend_i;
        dec_o.pend_nxt = 7'd0;
        dec_o.mode_nxt = MODE_OPCODE;
      end
      MODE_DISTANCE: begin
        dec_o.pend_nxt = 7'd0;
        dec_o.mode_nxt = MODE_OPCODE;
        if (underflow) begin
          err = 1'b1; dec_o.status = STAT_UNDERFLOW;
        end else if (ovf_out) begin
          err = 1'b1; dec_o.status = STAT_OUT_OVERRUN;
        end else begin
          dec_o.gen_len  = pend_i;
          dec_o.gen_copy = 1'b1;
        end
      end
      default: ;  // stream already closed, nothing decoded
    endcase

    prod_nxt = prod_i + LENGTH_BITS'(dec_o.gen_len);

    if (err) begin
      dec_o.done = 1'b1;
    end else if (fin || in_end) begin
      dec_o.done = 1'b1;
      if (dec_o.mode_nxt != MODE_OPCODE) dec_o.status = STAT_IN_OVERRUN;
      else if (prod_nxt == out_len_i)    dec_o.status = STAT_OK;
      else                               dec_o.status = STAT_MISMATCH;
    end

    if (dec_o.done) begin
      dec_o.mode_nxt = MODE_DONE;
      dec_o.pend_nxt = 7'd0;
    end
  end

  assign prod_nxt_o = prod_nxt;

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for the run/back-reference byte decoder unit.
`timescale 1ns / 100ps

module testbench;
  import rbbd_pkg::*;

  localparam int            LB          = DEF_LENGTH_BITS;
  localparam logic [LB-1:0] LEN_MAX     = '1;
  localparam logic [7:0]    OP_LIT_BASE = 8'd0;
  localparam int            STALL_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [1:0] byte_count;
    logic       run_end;
    logic       done_res;
    status_t    status;
  } res_t;

  typedef struct {
    logic [7:0] code;
    bit         typed;
    res_t       want;
  } plan_row_t;

  typedef enum {
    END_TERMINATOR, END_LENGTH, END_INVALID, END_LITERAL_SHORT,
    END_OPCODE_LAST, END_OUTPUT_SHORT, END_MID_LITERAL
  } ending_t;

  localparam res_t NO_RESULT = '0;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          cfg_we    = 1'b0;
  cfg_idx_t      cfg_index = CFG_INPUT_LENGTH;
  logic [LB-1:0] cfg_data  = '0;

  rbbd_in_if  in_ch ();
  rbbd_out_if out_ch ();

  run_backref_byte_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_ch),
    .out_m     (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Decoder state as the testbench sees it
  logic [LB-1:0] in_len   = LB'(1);
  logic [LB-1:0] out_len  = '0;
  logic [7:0]    ring [0:DEF_HISTORY_DEPTH-1];
  logic [8:0]    ring_ptr = '0;
  logic [LB-1:0] made     = '0;
  logic [LB-1:0] taken    = '0;
  mode_t         mode     = MODE_OPCODE;
  logic [6:0]    pend     = '0;
  logic [7:0]    fresh [$];
  res_t          step_out [$];
  res_t          owed [$];

  plan_row_t plan [20];
  bit        calm         = 1'b0;
  int        items_sent   = 0;
  int        results_seen = 0;
  int        bad_cnt      = 0;
  int        quiet        = 0;
  int        hold_left    = 0;

  function automatic res_t one_result(input logic [7:0] a, input logic [7:0] b,
                                      input logic [1:0] n);
    res_t r;
    r = '0;
    r.byte_a     = a;
    r.byte_b     = b;
    r.byte_count = n;
    r.run_end    = 1'b1;
    return r;
  endfunction

  function automatic string show(input res_t r);
    return $sformatf("a=%h b=%h n=%0d end=%b done=%b st=%0d",
                     r.byte_a, r.byte_b, r.byte_count, r.run_end, r.done_res, r.status);
  endfunction

  function automatic void store_byte(input logic [7:0] v);
    ring[ring_ptr] = v;
    ring_ptr = ring_ptr + 1'b1;
    made = made + 1'b1;
    fresh.push_back(v);
  endfunction

  // Decode one compressed byte; results for it land in step_out.
  function automatic void decode_step(input logic [7:0] code);
    logic [LB-1:0] room_in, room_out;
    logic [8:0]    distance;
    logic [6:0]    len;
    bit            stop, ended;
    status_t       st;
    res_t          r;
    step_out.delete();
    if (mode == MODE_DONE) return;
    fresh.delete();
    stop  = 1'b0;
    ended = 1'b0;
    st    = STAT_OK;
    taken = taken + 1'b1;
    room_in  = (in_len > taken) ? in_len - taken : '0;
    room_out = (out_len > made) ? out_len - made : '0;
    case (mode)
      MODE_OPCODE: begin
        if (code < OP_ZERO_BASE) begin
          len = code[6:0] + LIT_BIAS;
          if (len > room_in) begin
            stop = 1'b1; st = STAT_IN_OVERRUN;
          end else if (len > room_out) begin
            stop = 1'b1; st = STAT_OUT_OVERRUN;
          end else begin
            mode = MODE_LITERAL; pend = len;
          end
        end else if (code < OP_RUN_BASE) begin
          len = 7'(code - OP_ZERO_BASE) + SHORT_BIAS;
          if (len > room_out) begin
            stop = 1'b1; st = STAT_OUT_OVERRUN;
          end else begin
            for (int i = 0; i < len; i++) store_byte(8'h00);
          end
        end else if (code < OP_BREF_BASE) begin
          len = 7'(code - OP_RUN_BASE) + SHORT_BIAS;
          if (room_in == 0) begin
            stop = 1'b1; st = STAT_IN_OVERRUN;
          end else if (len > room_out) begin
            stop = 1'b1; st = STAT_OUT_OVERRUN;
          end else begin
            mode = MODE_RUN_DATA; pend = len;
          end
        end else if (code < OP_INVALID) begin
          if (room_in == 0) begin
            stop = 1'b1; st = STAT_IN_OVERRUN;
          end else begin
            mode = MODE_DISTANCE; pend = 7'(code - OP_BREF_BASE) + SHORT_BIAS;
          end
        end else if (code == OP_INVALID) begin
          stop = 1'b1; st = STAT_INVALID;
        end else begin
          ended = 1'b1;
        end
      end
      MODE_LITERAL: begin
        store_byte(code);
        pend = pend - 1'b1;
        if (pend == 0) mode = MODE_OPCODE;
      end
      MODE_RUN_DATA: begin
        for (int i = 0; i < pend; i++) store_byte(code);
        pend = '0;
        mode = MODE_OPCODE;
      end
      default: begin
        distance = {1'b0, code} + DIST_BIAS;
        len      = pend;
        pend     = '0;
        mode     = MODE_OPCODE;
        if (distance > made) begin
          stop = 1'b1; st = STAT_UNDERFLOW;
        end else if (len > room_out) begin
          stop = 1'b1; st = STAT_OUT_OVERRUN;
        end else begin
          // byte by byte, so an overlapping copy repeats its own output
          for (int i = 0; i < len; i++) store_byte(ring[9'(ring_ptr - distance)]);
        end
      end
    endcase
    if (!stop && !ended && taken >= in_len) ended = 1'b1;
    if (!stop && ended) begin
      stop = 1'b1;
      if (mode != MODE_OPCODE) st = STAT_IN_OVERRUN;
      else st = (made == out_len) ? STAT_OK : STAT_MISMATCH;
    end
    for (int k = 0; k < fresh.size(); k += 2) begin
      r = '0;
      r.byte_a = fresh[k];
      if (k + 1 < fresh.size()) begin
        r.byte_b     = fresh[k + 1];
        r.byte_count = 2'd2;
      end else begin
        r.byte_count = 2'd1;
      end
      step_out.push_back(r);
    end
    if (stop) begin
      r = '0;
      r.done_res = 1'b1;
      r.status   = st;
      step_out.push_back(r);
      mode = MODE_DONE;
      pend = '0;
    end
    if (step_out.size() != 0) step_out[step_out.size() - 1].run_end = 1'b1;
  endfunction

  task automatic push_byte(input logic [7:0] code, input bit typed = 1'b0,
                           input res_t want = NO_RESULT);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid   = 1'b1;
    in_ch.in_byte = code;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (mode != MODE_DONE) items_sent++;
    decode_step(code);
    if (typed) owed.push_back(want);
    else foreach (step_out[k]) owed.push_back(step_out[k]);
  endtask

  // Hold the sender off until every result is back and the engine has settled.
  task automatic quiesce();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_length(input cfg_idx_t idx, input logic [LB-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    if (idx == CFG_INPUT_LENGTH) in_len = value;
    else out_len = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One well-formed opcode with random content; lengths mostly short.
  task automatic send_random_op();
    int kind, len, span;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      len = ($urandom_range(0, 11) == 0) ? 64 : $urandom_range(1, 8);
      push_byte(OP_LIT_BASE + 8'(len - 1));
      repeat (len) push_byte(8'($urandom));
    end else if (kind < 5) begin
      len = ($urandom_range(0, 7) == 0) ? 65 : $urandom_range(2, 12);
      push_byte(OP_ZERO_BASE + 8'(len - 2));
    end else if (kind < 7) begin
      len = ($urandom_range(0, 7) == 0) ? 65 : $urandom_range(2, 12);
      push_byte(OP_RUN_BASE + 8'(len - 2));
      push_byte(8'($urandom));
    end else begin
      len  = ($urandom_range(0, 7) == 0) ? 63 : $urandom_range(2, 12);
      span = (made > 257) ? 257 : int'(made);
      push_byte(OP_BREF_BASE + 8'(len - 2));
      // distance never reaches past what has been produced
      push_byte(8'($urandom_range(0, span - 2)));
    end
  endtask

  // Output side: random backpressure bursts until the calm stretch
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready = 1'b0;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      hold_left    = $urandom_range(0, 8);
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.byte_a     = out_ch.byte_a;
      got.byte_b     = out_ch.byte_b;
      got.byte_count = out_ch.byte_count;
      got.run_end    = out_ch.run_end;
      got.done_res   = out_ch.done_res;
      got.status     = status_t'(out_ch.status);
      results_seen++;
      if (owed.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10) $display("%0t: unexpected result: %s", $time, show(got));
      end else begin
        want = owed.pop_front();
        if (got.byte_a !== want.byte_a || got.byte_b !== want.byte_b ||
            got.byte_count !== want.byte_count || got.run_end !== want.run_end ||
            got.done_res !== want.done_res || got.status !== want.status) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("%0t: mismatch: expected %s, actual %s", $time, show(want), show(got));
        end
      end
    end
  end

  // Watchdog: a long stretch with no transfer on either channel ends the run.
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      quiet = 0;
    else
      quiet++;
    if (quiet == STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results owed", quiet, owed.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    ending_t ending;
    int      r;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    out_ch.ready  = 1'b0;
    plan = '{
      '{OP_ZERO_BASE,         1'b1, one_result(8'h00, 8'h00, 2'd2)},
      '{OP_BREF_BASE,         1'b0, NO_RESULT},
      '{8'h00,                1'b1, one_result(8'h00, 8'h00, 2'd2)}, // distance == produced
      '{OP_LIT_BASE,          1'b0, NO_RESULT},
      '{8'hFF,                1'b1, one_result(8'hFF, 8'h00, 2'd1)},
      '{OP_RUN_BASE,          1'b0, NO_RESULT},
      '{8'hAA,                1'b1, one_result(8'hAA, 8'hAA, 2'd2)},
      '{OP_LIT_BASE + 8'd1,   1'b0, NO_RESULT},
      '{8'h55,                1'b1, one_result(8'h55, 8'h00, 2'd1)},
      '{8'hA5,                1'b1, one_result(8'hA5, 8'h00, 2'd1)},
      '{OP_ZERO_BASE + 8'd63, 1'b0, NO_RESULT},
      '{OP_RUN_BASE + 8'd63,  1'b0, NO_RESULT},
      '{8'h3C,                1'b0, NO_RESULT},
      '{OP_BREF_BASE + 8'd61, 1'b0, NO_RESULT},
      '{8'h01,                1'b0, NO_RESULT},                     // overlapping copy
      '{OP_RUN_BASE + 8'd1,   1'b0, NO_RESULT},
      '{8'h5A,                1'b0, NO_RESULT},
      '{OP_ZERO_BASE + 8'd63, 1'b0, NO_RESULT},
      '{OP_BREF_BASE,         1'b0, NO_RESULT},
      '{8'hFF,                1'b0, NO_RESULT}                      // farthest distance
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    set_length(CFG_INPUT_LENGTH, LEN_MAX);
    set_length(CFG_OUTPUT_LENGTH, LEN_MAX);
    foreach (plan[i]) push_byte(plan[i].code, plan[i].typed, plan[i].want);
    quiesce();

    set_length(CFG_INPUT_LENGTH, LB'($urandom_range(1 << 23, (1 << 24) - 1)));
    set_length(CFG_OUTPUT_LENGTH, LB'($urandom_range(1 << 22, (1 << 24) - 2)));
    while (items_sent < 70) send_random_op();
    quiesce();
    set_length(CFG_INPUT_LENGTH, taken + LB'($urandom_range(5000, 90000)));
    set_length(CFG_OUTPUT_LENGTH, LEN_MAX);
    while (items_sent < 115) send_random_op();
    quiesce();
    calm = 1'b1;
    while (items_sent < 155) send_random_op();
    quiesce();

    // Only one way out of the stream per run; the seed picks it.
    ending = ending_t'($urandom_range(0, 6));
    r = $urandom_range(0, 1);
    case (ending)
      END_TERMINATOR: begin
        set_length(CFG_OUTPUT_LENGTH, made + LB'(r));
        push_byte(OP_END);
      end
      END_LENGTH: begin
        set_length(CFG_OUTPUT_LENGTH, made + LB'(2 + $urandom_range(0, 1)));
        if (r != 0) begin
          set_length(CFG_INPUT_LENGTH, '0);  // zero length behaves as one
          push_byte(OP_ZERO_BASE);
        end else begin
          set_length(CFG_INPUT_LENGTH, taken + LB'(3));
          push_byte(OP_LIT_BASE + 8'd1);
          push_byte(8'($urandom));
          push_byte(8'($urandom));
        end
      end
      END_INVALID: push_byte(OP_INVALID);
      END_LITERAL_SHORT: begin
        set_length(CFG_INPUT_LENGTH, taken + LB'(3));
        push_byte(OP_LIT_BASE + 8'd63);
      end
      END_OPCODE_LAST: begin
        set_length(CFG_INPUT_LENGTH, taken + LB'(1));
        if (r != 0) push_byte(OP_RUN_BASE + 8'($urandom_range(0, 63)));
        else push_byte(OP_BREF_BASE + 8'($urandom_range(0, 61)));
      end
      END_OUTPUT_SHORT: begin
        set_length(CFG_OUTPUT_LENGTH, '0);
        if (r != 0) begin
          push_byte(OP_ZERO_BASE + 8'($urandom_range(0, 63)));
        end else begin
          // overrun on a back-reference shows at its distance byte
          push_byte(OP_BREF_BASE);
          push_byte(8'h00);
        end
      end
      default: begin
        // input length cut while a literal run is still open
        push_byte(OP_LIT_BASE + 8'd3);
        quiesce();
        set_length(CFG_INPUT_LENGTH, taken + LB'(1));
        push_byte(8'($urandom));
      end
    endcase
    // stream is closed; these must vanish
    repeat (3) push_byte(8'($urandom));
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Fed %0d compressed bytes, %0d bytes decoded, %0d results checked.",
             items_sent, made, results_seen);
    $display("Literal, zero, repeat and overlapped back-reference runs; stream closed by %s.",
             ending.name());
    if (bad_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
